// ===== hdl/toeq_pkg.sv =====
// ----------------------------------------------------------------------------
// toeq_pkg
// Types and codes shared by the time-ordered event queue modules.
// ----------------------------------------------------------------------------
package toeq_pkg;

  localparam logic [2:0] KIND_ADD  = 3'd0;
  localparam logic [2:0] KIND_REM  = 3'd1;
  localparam logic [2:0] KIND_FIND = 3'd2;
  localparam logic [2:0] KIND_ADV  = 3'd3;
  localparam logic [2:0] KIND_POP  = 3'd4;

  localparam logic [1:0] TYPE_DISPATCH = 2'd0;
  localparam logic [1:0] TYPE_ADD      = 2'd1;
  localparam logic [1:0] TYPE_REM      = 2'd2;
  localparam logic [1:0] TYPE_FIND     = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         event_code;
    logic [31:0]        event_param;
    logic signed [63:0] rel_time;
    logic [63:0]        new_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_type;
    logic [7:0]  out_code;
    logic [31:0] out_arg;
    logic [63:0] out_time;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [63:0] due;
    logic [7:0]  code;
    logic [31:0] arg;
  } entry_t;

endpackage

// ===== hdl/time_ordered_event_queue_core.sv =====
// ----------------------------------------------------------------------------
// time_ordered_event_queue_core
// Sorted timed-event queue with add, remove, find, advance and pop commands.
// ----------------------------------------------------------------------------
// Usage:
//  in_valid/in_ready/in_data carry one command per transfer; out_valid/
//  out_ready/out_data carry results. Kinds 5..7 are taken and ignored.
//  A two-entry command queue sits between the front end and the sequencer,
//  so commands are taken while the sequencer is busy or the output stalls.
//  Add walks back from the tail, moving each later entry up one slot;
//  remove and find scan from the head, and remove then shifts each
//  later entry down one slot; pop takes the head entry; advance
//  dispatches each due event in turn. The longest command is an advance
//  that empties a full queue. The sequencer walks the event memory one
//  entry at a time and takes no new command until done with the last.
//  Advance emits one result per due event; last marks the final one.
//  Reset (rst_n low, synchronous) empties the queue and zeroes the time.
//  When out_ready is low the result is held and the sequencer waits; the
//  command queue then fills and in_ready drops.
// ----------------------------------------------------------------------------
module time_ordered_event_queue_core
  import toeq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic     cmd_valid, cmd_ready;
  in_item_t cmd_data;

  toeq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_data  (cmd_data)
  );

  toeq_back #(.DEPTH(DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_data  (cmd_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/toeq_front.sv =====
// ----------------------------------------------------------------------------
// toeq_front
// Accepts input items, drops unused kinds, queues commands for the back end.
// ----------------------------------------------------------------------------
module toeq_front
  import toeq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output in_item_t cmd_data
);

  in_item_t   q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop, kind_ok;

  always_comb begin
    case (in_data.kind)
      KIND_ADD, KIND_REM, KIND_FIND, KIND_ADV, KIND_POP: kind_ok = 1'b1;
      default: kind_ok = 1'b0;
    endcase
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid && in_ready && kind_ok;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd_data  = q_r[rp_r];
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= in_data;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== hdl/toeq_back.sv =====
// ----------------------------------------------------------------------------
// toeq_back
// Sorted event store in a circular memory and the sequencer that walks it.
// ----------------------------------------------------------------------------
module toeq_back
  import toeq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  in_item_t  cmd_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_ADD_RD  = 13'b0000000000010,
    S_ADD_CMP = 13'b0000000000100,
    S_REM_RD  = 13'b0000000001000,
    S_REM_CMP = 13'b0000000010000,
    S_SH_RD   = 13'b0000000100000,
    S_SH_WR   = 13'b0000001000000,
    S_FND_RD  = 13'b0000010000000,
    S_FND_CMP = 13'b0000100000000,
    S_ADV_RD  = 13'b0001000000000,
    S_ADV_CMP = 13'b0010000000000,
    S_POP_CMP = 13'b0100000000000,
    S_EMIT    = 13'b1000000000000
  } state_t;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  state_t    state_r, state_nxt, ret_r, ret_nxt;
  in_item_t  cmd_r, cmd_nxt;
  logic [63:0] due_r, due_nxt, cur_r, cur_nxt;
  logic [CW-1:0] li_r, li_nxt, fill_r, fill_nxt;
  logic [AW-1:0] head_r, head_nxt;
  out_item_t res_r, res_nxt, out_data_r;
  entry_t    pend_r, pend_nxt;
  logic      have_pend_r, have_pend_nxt, out_valid_r;

  logic          wr_en;
  logic [CW-1:0] wr_li, rd_li;
  entry_t        wr_data, new_ent;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          out_free;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [CW-1:0] li);
    logic [AW:0] s;
    s = {1'b0, head} + {1'b0, li[AW-1:0]};
    if (s >= (AW+1)'(DEPTH)) s = s - (AW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  function automatic out_item_t mk_res(input logic [1:0] t, input entry_t e,
                                       input logic [1:0] st, input logic lst);
    out_item_t r;
    r.out_type = t;
    r.out_code = e.code;
    r.out_arg  = e.arg;
    r.out_time = e.due;
    r.status   = st;
    r.last     = lst;
    return r;
  endfunction

  assign out_free  = !out_valid_r || out_ready;
  assign cmd_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign new_ent   = '{due: due_r, code: cmd_r.event_code, arg: cmd_r.event_param};
  assign rd_addr   = phys(head_nxt, rd_li);
  assign wr_addr   = phys(head_r, wr_li);

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    cmd_nxt       = cmd_r;
    due_nxt       = due_r;
    cur_nxt       = cur_r;
    li_nxt        = li_r;
    fill_nxt      = fill_r;
    head_nxt      = head_r;
    res_nxt       = res_r;
    pend_nxt      = pend_r;
    have_pend_nxt = have_pend_r;
    wr_en         = 1'b0;
    wr_li         = li_r;
    wr_data       = rd_data_r;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_nxt = cmd_data;
          due_nxt = cur_r + cmd_data.rel_time;
          li_nxt  = '0;
          ret_nxt = S_IDLE;
          case (cmd_data.kind)
            KIND_ADD: begin
              if (fill_r == CW'(DEPTH)) begin
                res_nxt   = mk_res(TYPE_ADD, '0, ST_FULL, 1'b1);
                state_nxt = S_EMIT;
              end else begin
                li_nxt    = fill_r;
                state_nxt = S_ADD_RD;
              end
            end
            KIND_REM:  state_nxt = S_REM_RD;
            KIND_FIND: state_nxt = S_FND_RD;
            KIND_ADV: begin
              cur_nxt       = cmd_data.new_time;
              have_pend_nxt = 1'b0;
              state_nxt     = S_ADV_RD;
            end
            KIND_POP: begin
              if (fill_r == '0) begin
                res_nxt   = mk_res(TYPE_DISPATCH, '0, ST_EMPTY, 1'b1);
                state_nxt = S_EMIT;
              end else begin
                state_nxt = S_POP_CMP;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD_RD: begin
        if (li_r == '0) begin
          wr_en     = 1'b1;
          wr_data   = new_ent;
          fill_nxt  = fill_r + 1'b1;
          res_nxt   = mk_res(TYPE_ADD, '0, ST_OK, 1'b1);
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_ADD_CMP;
        end
      end
      S_ADD_CMP: begin
        wr_en = 1'b1;
        if (due_r < rd_data_r.due) begin
          li_nxt    = li_r - 1'b1;
          state_nxt = S_ADD_RD;
        end else begin
          wr_data   = new_ent;
          fill_nxt  = fill_r + 1'b1;
          res_nxt   = mk_res(TYPE_ADD, '0, ST_OK, 1'b1);
          state_nxt = S_EMIT;
        end
      end
      S_REM_RD: begin
        if (li_r == fill_r) begin
          res_nxt   = mk_res(TYPE_REM, '0, ST_NOT_FOUND, 1'b1);
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_REM_CMP;
        end
      end
      S_REM_CMP: begin
        if (rd_data_r.code == cmd_r.event_code && rd_data_r.arg == cmd_r.event_param) begin
          state_nxt = S_SH_RD;
        end else begin
          li_nxt    = li_r + 1'b1;
          state_nxt = S_REM_RD;
        end
      end
      // close the gap: move each later entry down one slot
      S_SH_RD: begin
        if ((li_r + 1'b1) >= fill_r) begin
          fill_nxt  = fill_r - 1'b1;
          res_nxt   = mk_res(TYPE_REM, '0, ST_OK, 1'b1);
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_SH_WR;
        end
      end
      S_SH_WR: begin
        wr_en     = 1'b1;
        li_nxt    = li_r + 1'b1;
        state_nxt = S_SH_RD;
      end
      S_FND_RD: begin
        if (li_r == fill_r) begin
          res_nxt   = mk_res(TYPE_FIND, '{due: '1, code: '0, arg: '0},
                             ST_NOT_FOUND, 1'b1);
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_FND_CMP;
        end
      end
      S_FND_CMP: begin
        if (rd_data_r.code == cmd_r.event_code) begin
          res_nxt   = mk_res(TYPE_FIND, '{due: rd_data_r.due, code: '0, arg: '0},
                             ST_OK, 1'b1);
          state_nxt = S_EMIT;
        end else begin
          li_nxt    = li_r + 1'b1;
          state_nxt = S_FND_RD;
        end
      end
      // one dispatched event is held back so last can be set on the final one
      S_ADV_RD: begin
        if (fill_r == '0) begin
          if (have_pend_r) begin
            res_nxt       = mk_res(TYPE_DISPATCH, pend_r, ST_OK, 1'b1);
            have_pend_nxt = 1'b0;
            state_nxt     = S_EMIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_ADV_CMP;
        end
      end
      S_ADV_CMP: begin
        if (rd_data_r.due <= cmd_r.new_time) begin
          head_nxt      = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
          fill_nxt      = fill_r - 1'b1;
          pend_nxt      = rd_data_r;
          have_pend_nxt = 1'b1;
          if (have_pend_r) begin
            res_nxt   = mk_res(TYPE_DISPATCH, pend_r, ST_OK, 1'b0);
            ret_nxt   = S_ADV_RD;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_ADV_RD;
          end
        end else if (have_pend_r) begin
          res_nxt       = mk_res(TYPE_DISPATCH, pend_r, ST_OK, 1'b1);
          have_pend_nxt = 1'b0;
          state_nxt     = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_POP_CMP: begin
        cur_nxt   = rd_data_r.due;
        head_nxt  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
        fill_nxt  = fill_r - 1'b1;
        res_nxt   = mk_res(TYPE_DISPATCH, rd_data_r, ST_OK, 1'b1);
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) state_nxt = ret_r;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    case (state_r)
      S_ADD_RD: rd_li = li_r - 1'b1;
      S_SH_RD:  rd_li = li_r + 1'b1;
      S_ADV_RD: rd_li = '0;
      S_IDLE:   rd_li = '0;
      default:  rd_li = li_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    due_r  <= due_nxt;
    li_r   <= li_nxt;
    res_r  <= res_nxt;
    pend_r <= pend_nxt;
    ret_r  <= ret_nxt;
    if (state_r == S_EMIT && out_free) out_data_r <= res_r;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      head_r      <= '0;
      cur_r       <= '0;
      have_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      head_r      <= head_nxt;
      cur_r       <= cur_nxt;
      have_pend_r <= have_pend_nxt;
      if (state_r == S_EMIT && out_free) out_valid_r <= 1'b1;
      else if (out_ready)                out_valid_r <= 1'b0;
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(DEPTH)) else $error("fill count above depth");
  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !have_pend_r) else $error("held dispatch left behind");
  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (fill_r == $past(fill_r) || fill_r == $past(fill_r) + 1'b1 ||
         fill_r == $past(fill_r) - 1'b1)) else $error("fill count jumped");
`endif

endmodule
